FILE: sv/cdd_pkg.sv
// Shared types, constants and helper functions for the calendar date decrement block.
package cdd_pkg;

  localparam int AMOUNT_WIDTH_DEF = 16;

  localparam logic [1:0] MODE_DAY   = 2'd0;
  localparam logic [1:0] MODE_MONTH = 2'd1;
  localparam logic [1:0] MODE_YEAR  = 2'd2;

  localparam logic [12:0] RECIP_25    = 13'd5242;
  localparam int          RECIP_SHIFT = 17;

  localparam logic [8:0]  RES_AT_MIN_YEAR_WRAP = 9'd367;
  localparam logic [9:0]  MIN_YEAR_RES_OFFSET  = 10'd32;
  localparam logic [9:0]  CYCLE_YEARS          = 10'd400;
  localparam logic [15:0] YEAR_MIN             = 16'h8000;

  localparam logic [4:0] MONTH_LEN [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        amount;
    logic [4:0]         day_in;
    logic [3:0]         month_in;
    logic signed [15:0] year_in;
  } cdd_in_t;

  typedef struct packed {
    logic [4:0]         day_out;
    logic [3:0]         month_out;
    logic signed [15:0] year_out;
  } cdd_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MOD,
    ST_RES,
    ST_RUN,
    ST_DONE
  } cdd_state_t;

  typedef struct packed {
    logic load;
    logic prep_mul;
    logic prep_mod;
    logic prep_res;
    logic step;
    logic year_sub;
    logic emit;
  } cdd_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic steps;
    logic is_year;
    logic out_free;
  } cdd_sts_t;

  function automatic logic is_leap(input logic [8:0] res);
    return (res == 9'd0) ||
           ((res[1:0] == 2'd0) && (res != 9'd100) && (res != 9'd200) && (res != 9'd300));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    len = 5'd31;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if ((m >= 4'd1) && (m <= 4'd12)) begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

FILE: sv/calendar_date_decrement.sv
// Top level of the calendar date decrement block.
// Sequence: ST_MUL, ST_MOD and ST_RES set up the leap residue; ST_RUN steps back one
// day or month per unit in day and month modes, subtracts the years in year mode and
// leaves mode three as loaded; then ST_DONE emits the result. One beat is in the core
// at a time, but the result register lets the next beat in while a result waits.
// Reset: rst_n synchronous, active low; clears the sequencer and out_valid.
module calendar_date_decrement #(
  parameter int AMOUNT_WIDTH = cdd_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdd_pkg::cdd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cdd_pkg::cdd_out_t out_data
);

  cdd_pkg::cdd_cmd_t cmd;
  cdd_pkg::cdd_sts_t sts;

  cdd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdd_dp #(
    .AMOUNT_WIDTH (AMOUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result written over an untaken beat");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready while a beat is in progress");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result shown without an emit");

  a_step_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!sts.cnt_zero && sts.steps))
    else $error("step issued with no count left");

endmodule

FILE: sv/cdd_ctrl.sv
// Sequencing state machine for the calendar date decrement block.
module cdd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  cdd_pkg::cdd_sts_t sts,
  output cdd_pkg::cdd_cmd_t cmd
);

  cdd_pkg::cdd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = cdd_pkg::ST_MUL;
      end
      cdd_pkg::ST_MUL: state_nxt = cdd_pkg::ST_MOD;
      cdd_pkg::ST_MOD: state_nxt = cdd_pkg::ST_RES;
      cdd_pkg::ST_RES: state_nxt = cdd_pkg::ST_RUN;
      cdd_pkg::ST_RUN: begin
        if (!(sts.steps && !sts.cnt_zero)) state_nxt = cdd_pkg::ST_DONE;
      end
      cdd_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = cdd_pkg::ST_IDLE;
      end
      default: state_nxt = cdd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      cdd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cdd_pkg::ST_MUL: cmd.prep_mul = 1'b1;
      cdd_pkg::ST_MOD: cmd.prep_mod = 1'b1;
      cdd_pkg::ST_RES: cmd.prep_res = 1'b1;
      cdd_pkg::ST_RUN: begin
        cmd.step     = sts.steps && !sts.cnt_zero;
        cmd.year_sub = sts.is_year;
      end
      cdd_pkg::ST_DONE: cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: sv/cdd_dp.sv
// Date registers, leap residue tracking, step logic and output register.
module cdd_dp #(
  parameter int AMOUNT_WIDTH = cdd_pkg::AMOUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cdd_pkg::cdd_in_t  in_data,
  input  cdd_pkg::cdd_cmd_t cmd,
  output cdd_pkg::cdd_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output cdd_pkg::cdd_out_t out_data
);

  logic [1:0]              mode_r, mode_nxt;
  logic [AMOUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [4:0]              day_r, day_nxt;
  logic [3:0]              mon_r, mon_nxt;
  logic [15:0]             year_r, year_nxt;
  logic [8:0]              res_r, res_nxt;
  logic [24:0]             prod_r, prod_nxt;
  logic [4:0]              r25_r, r25_nxt;
  logic                    out_valid_r, out_valid_nxt;
  cdd_pkg::cdd_out_t       out_data_r, out_data_nxt;

  logic [31:0] amt32;
  logic [31:0] cnt32;
  logic [4:0]  day0;
  logic [3:0]  mon0;
  logic [11:0] x12;
  logic [7:0]  q8;
  logic [12:0] q25;
  logic [12:0] t13;
  logic [5:0]  t6;
  logic [9:0]  r400;
  logic [9:0]  res_sum;
  logic        mon_wrap;
  logic [3:0]  mon_step;
  logic [15:0] year_step;
  logic [8:0]  res_dec;
  logic [8:0]  res_step;
  logic [4:0]  lim;

  assign amt32 = {16'b0, in_data.amount};
  assign cnt32 = 32'(cnt_r);
  assign day0  = (in_data.day_in == 5'd0) ? 5'd1 : in_data.day_in;
  assign mon0  = (in_data.month_in == 4'd0) ? 4'd1 :
                 (in_data.month_in > 4'd12) ? 4'd12 : in_data.month_in;

  assign x12     = year_r[15:4] ^ 12'h800;
  assign q8      = prod_r[24:cdd_pkg::RECIP_SHIFT];
  assign q25     = 13'(q8) * 13'd25;
  assign t13     = {1'b0, x12} - q25;
  assign t6      = t13[5:0];
  assign r400    = {1'b0, r25_r, year_r[3:0]};
  assign res_sum = r400 + cdd_pkg::MIN_YEAR_RES_OFFSET;

  assign mon_wrap  = (mon_r == 4'd1);
  assign mon_step  = mon_wrap ? 4'd12 : mon_r - 4'd1;
  assign year_step = mon_wrap ? year_r - 16'd1 : year_r;
  assign res_dec   = (year_r == cdd_pkg::YEAR_MIN) ? cdd_pkg::RES_AT_MIN_YEAR_WRAP :
                     (res_r == 9'd0) ? 9'd399 : res_r - 9'd1;
  assign res_step  = mon_wrap ? res_dec : res_r;
  assign lim       = cdd_pkg::month_days(mon_step, cdd_pkg::is_leap(res_step));

  always_comb begin
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    day_nxt       = day_r;
    mon_nxt       = mon_r;
    year_nxt      = year_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    r25_nxt       = r25_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      mode_nxt = in_data.mode;
      cnt_nxt  = amt32[AMOUNT_WIDTH-1:0];
      day_nxt  = day0;
      mon_nxt  = mon0;
      year_nxt = in_data.year_in;
    end
    if (cmd.prep_mul) begin
      prod_nxt = 25'(x12) * 25'(cdd_pkg::RECIP_25);
    end
    if (cmd.prep_mod) begin
      r25_nxt = (t6 >= 6'd25) ? 5'(t6 - 6'd25) : t6[4:0];
    end
    if (cmd.prep_res) begin
      res_nxt = (res_sum >= cdd_pkg::CYCLE_YEARS) ?
                9'(res_sum - cdd_pkg::CYCLE_YEARS) : res_sum[8:0];
    end
    if (cmd.step) begin
      cnt_nxt = cnt_r - AMOUNT_WIDTH'(1);
      if (mode_r == cdd_pkg::MODE_MONTH) begin
        mon_nxt  = mon_step;
        year_nxt = year_step;
        res_nxt  = res_step;
        day_nxt  = (day_r > lim) ? lim : day_r;
      end else if (day_r == 5'd1) begin
        mon_nxt  = mon_step;
        year_nxt = year_step;
        res_nxt  = res_step;
        day_nxt  = lim;
      end else begin
        day_nxt = day_r - 5'd1;
      end
    end
    if (cmd.year_sub) begin
      year_nxt = year_r - cnt32[15:0];
    end
    if (cmd.emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.day_out   = day_r;
      out_data_nxt.month_out = mon_r;
      out_data_nxt.year_out  = year_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    cnt_r      <= cnt_nxt;
    day_r      <= day_nxt;
    mon_r      <= mon_nxt;
    year_r     <= year_nxt;
    res_r      <= res_nxt;
    prod_r     <= prod_nxt;
    r25_r      <= r25_nxt;
    out_data_r <= out_data_nxt;
  end

  assign sts.cnt_zero = (cnt_r == '0);
  assign sts.steps    = (mode_r == cdd_pkg::MODE_DAY) || (mode_r == cdd_pkg::MODE_MONTH);
  assign sts.is_year  = (mode_r == cdd_pkg::MODE_YEAR);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: tb/sv/calendar_date_decrement_tb.sv
// Self-checking testbench for calendar_date_decrement: directed and random dates, checked on the fly.
module calendar_date_decrement_tb;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int QUIET_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_ITEMS = 76;
  localparam int SHOWN_ERRORS = 10;

  class date_scoreboard;
    cdd_pkg::cdd_out_t due_dates[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function bit leap_year(logic [15:0] y);
      int v;
      v = int'($signed(y));
      return (v % 400 == 0) || ((v % 100 != 0) && (v % 4 == 0));
    endfunction

    function logic [4:0] month_length(logic [3:0] m, logic [15:0] y);
      case (m)
        4'd2: return leap_year(y) ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
        default: return 5'd31;
      endcase
    endfunction

    function void back_one_month(inout logic [3:0] m, inout logic [15:0] y);
      if (m == 4'd1) begin
        m = 4'd12;
        y = y - 16'd1;
      end else begin
        m = m - 4'd1;
      end
    endfunction

    function cdd_pkg::cdd_out_t earlier_date(cdd_pkg::cdd_in_t req);
      logic [4:0]        d;
      logic [3:0]        m;
      logic [15:0]       y;
      logic [4:0]        lim;
      int                n;
      cdd_pkg::cdd_out_t res;
      d = (req.day_in == 5'd0) ? 5'd1 : req.day_in;
      if (req.month_in == 4'd0) begin
        m = 4'd1;
      end else if (req.month_in > 4'd12) begin
        m = 4'd12;
      end else begin
        m = req.month_in;
      end
      y = req.year_in;
      case (req.mode)
        cdd_pkg::MODE_DAY: begin
          for (n = 0; n < int'(req.amount); n++) begin
            if (d == 5'd1) begin
              back_one_month(m, y);
              d = month_length(m, y);
            end else begin
              d = d - 5'd1;
            end
          end
        end
        cdd_pkg::MODE_MONTH: begin
          for (n = 0; n < int'(req.amount); n++) begin
            back_one_month(m, y);
            lim = month_length(m, y);
            if (d > lim) d = lim;
          end
        end
        cdd_pkg::MODE_YEAR: y = y - req.amount;
        default: ;
      endcase
      res.day_out   = d;
      res.month_out = m;
      res.year_out  = y;
      return res;
    endfunction

    function void note_request(cdd_pkg::cdd_in_t req);
      due_dates.push_back(earlier_date(req));
    endfunction

    function void check_result(cdd_pkg::cdd_out_t got);
      cdd_pkg::cdd_out_t want;
      if (due_dates.size() == 0) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("result with nothing pending: %0d/%0d/%0d",
                   got.day_out, got.month_out, got.year_out);
        return;
      end
      want = due_dates.pop_front();
      if (got.day_out !== want.day_out || got.month_out !== want.month_out ||
          got.year_out !== want.year_out) begin
        errors++;
        if (errors <= SHOWN_ERRORS)
          $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                   want.day_out, want.month_out, want.year_out,
                   got.day_out, got.month_out, got.year_out);
      end
    endfunction

    function bit failed();
      return (errors != 0) || (due_dates.size() != 0);
    endfunction
  endclass

  logic              clk;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  cdd_pkg::cdd_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cdd_pkg::cdd_out_t out_data;

  date_scoreboard sb = new();
  int sent     = 0;
  int received = 0;
  int quiet    = 0;

  calendar_date_decrement u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_date(cdd_pkg::cdd_in_t req);
    int gap;
    gap = (sent % 36 >= 24) ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(req);
    sent++;
  endtask

  task automatic send_fields(logic [1:0] mode, int amount, int day, int month, int year);
    cdd_pkg::cdd_in_t req;
    req.mode     = mode;
    req.amount   = 16'(amount);
    req.day_in   = 5'(day);
    req.month_in = 4'(month);
    req.year_in  = 16'(year);
    send_date(req);
  endtask

  function automatic cdd_pkg::cdd_in_t random_request();
    cdd_pkg::cdd_in_t req;
    int               pick;
    pick = int'($urandom_range(0, 9));
    req.mode = (pick == 0) ? MODE_NONE : (pick < 4) ? cdd_pkg::MODE_DAY :
               (pick < 7) ? cdd_pkg::MODE_MONTH : cdd_pkg::MODE_YEAR;
    pick = int'($urandom_range(0, 24));
    if (req.mode == cdd_pkg::MODE_YEAR || req.mode == MODE_NONE || pick == 0) begin
      req.amount = 16'($urandom);
    end else if (pick < 4) begin
      req.amount = 16'($urandom_range(0, 2000));
    end else begin
      req.amount = 16'($urandom_range(0, 60));
    end
    req.day_in = ($urandom_range(0, 15) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    pick = int'($urandom_range(0, 19));
    if (pick == 0) begin
      req.month_in = 4'd0;
    end else if (pick == 1) begin
      req.month_in = 4'($urandom_range(13, 15));
    end else begin
      req.month_in = 4'($urandom_range(1, 12));
    end
    case ($urandom_range(0, 3))
      0: req.year_in = 16'($urandom);
      1: req.year_in = 16'h8000 + 16'($urandom_range(0, 3));
      2: req.year_in = 16'($urandom_range(1896, 2104));
      default: req.year_in = 16'($urandom_range(0, 808)) - 16'd404;
    endcase
    return req;
  endfunction

  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = (received % 30 >= 20) ? 0 : int'($urandom_range(0, 10));
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_data);
      received++;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_fields(cdd_pkg::MODE_DAY,   0,     0,  0,  0);
    send_fields(cdd_pkg::MODE_DAY,   0,     31, 2,  2023);
    send_fields(cdd_pkg::MODE_DAY,   1,     1,  3,  2024);
    send_fields(cdd_pkg::MODE_DAY,   1,     1,  3,  1900);
    send_fields(cdd_pkg::MODE_DAY,   1,     1,  3,  2000);
    send_fields(cdd_pkg::MODE_DAY,   1,     1,  3,  -4);
    send_fields(cdd_pkg::MODE_DAY,   1,     1,  3,  -100);
    send_fields(cdd_pkg::MODE_DAY,   1,     1,  3,  -400);
    send_fields(cdd_pkg::MODE_DAY,   1,     1,  1,  -32768);
    send_fields(cdd_pkg::MODE_DAY,   1,     31, 2,  2023);
    send_fields(cdd_pkg::MODE_DAY,   1,     0,  0,  5);
    send_fields(cdd_pkg::MODE_DAY,   0,     12, 15, 77);
    send_fields(cdd_pkg::MODE_DAY,   65535, 31, 12, 32767);
    send_fields(cdd_pkg::MODE_MONTH, 1,     31, 3,  2023);
    send_fields(cdd_pkg::MODE_MONTH, 2,     31, 5,  2023);
    send_fields(cdd_pkg::MODE_MONTH, 12,    29, 2,  2024);
    send_fields(cdd_pkg::MODE_MONTH, 1,     15, 1,  -32768);
    send_fields(cdd_pkg::MODE_MONTH, 65535, 31, 12, -1);
    send_fields(cdd_pkg::MODE_YEAR,  1,     29, 2,  2024);
    send_fields(cdd_pkg::MODE_YEAR,  0,     31, 13, -32768);
    send_fields(cdd_pkg::MODE_YEAR,  65535, 31, 12, 32767);
    send_fields(cdd_pkg::MODE_YEAR,  65535, 0,  0,  0);
    send_fields(MODE_NONE,           1234,  0,  13, -1);
    send_fields(MODE_NONE,           65535, 31, 15, 32767);

    repeat (RANDOM_ITEMS) send_date(random_request());
    in_valid <= 1'b0;

    while (sb.due_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failed()) begin
      $display("DONE: errors detected");
    end else begin
      $display("DONE: 0 errors");
    end
    $finish;
  end

endmodule
